[src/mfek_pkg.sv]
// ----------------------------------------------------------------------------
// mfek_pkg: shared types and constants for the max flow engine
// Graph sizes, derived widths, arc record layout and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfek_pkg;

  localparam int MAX_NODES = 256;
  localparam int MAX_ARCS  = 512;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int ARC_W  = $clog2(MAX_ARCS);
  localparam int CNT_W  = ARC_W + 1;
  localparam int QPTR_W = NODE_W + 1;

  localparam int CAP_W   = 30;
  localparam int FLOW_W  = 31;
  localparam int BOT_W   = 31;
  localparam int TOTAL_W = 39;

  localparam logic [CNT_W-1:0] ARC_EMPTY = CNT_W'(MAX_ARCS);
  localparam logic [BOT_W-1:0] START_BOT = BOT_W'(32'h4000_0000);

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] tail;
    logic [NODE_W-1:0] head;
    logic [CAP_W-1:0]  cap;
    logic [FLOW_W-1:0] flow;
    logic [CNT_W-1:0]  next;
  } arc_t;

  typedef struct packed {
    logic [ARC_W-1:0] parent;
    logic [BOT_W-1:0] bot;
  } node_t;

endpackage

[src/mfek_ram.sv]
// ----------------------------------------------------------------------------
// mfek_ram: generic single write port ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfek_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/max_flow_edmonds_karp_top.sv]
// add edge: the request is checked, both arcs are written and the result is loaded to the output;
//   a dropped edge skips the arc writes; a new request is taken the cycle after the result loads
// solve: a request check, then repeated searches that dequeue nodes, scan their arcs and update
//   both arcs along each augmenting path; one request in flight at a time
// reset clears the sequencer, arc count and adjacency valid bits at once;
// no clearing pass is needed
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp_top: edmonds-karp maximum flow engine
// Loads edges into an arc store and solves max flow by repeated bfs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_flow_edmonds_karp_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // edge_from[7:0], edge_to[15:8], capacity[45:16], source_node[53:46],
  // sink_node[61:54], zero[63:62]
  input  logic [63:0] s_axis_tdata,
  // command[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // max_flow[38:0], zero[39]
  output logic [39:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int NW = mfek_pkg::NODE_W;
  localparam int AW = mfek_pkg::ARC_W;
  localparam int CW = mfek_pkg::CNT_W;
  localparam int QW = mfek_pkg::QPTR_W;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_ADD_CHK = 16'h0002,
    S_ADD_W0  = 16'h0004,
    S_ADD_W1  = 16'h0008,
    S_SLV_CHK = 16'h0010,
    S_INIT    = 16'h0020,
    S_DEQ     = 16'h0040,
    S_DEQ_RD  = 16'h0080,
    S_DEQ_LD  = 16'h0100,
    S_ARC_RD  = 16'h0200,
    S_ARC_EV  = 16'h0400,
    S_AUG_RD  = 16'h0800,
    S_AUG_P   = 16'h1000,
    S_AUG_F   = 16'h2000,
    S_AUG_R   = 16'h4000,
    S_DONE    = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // request fields
  logic                        cmd_q;
  logic [7:0]                  from8_q, to8_q, src8_q, snk8_q;
  logic [mfek_pkg::CAP_W-1:0]  cap_q;
  logic [NW-1:0]               from_n, to_n, src_n, snk_n;

  // control and working registers
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [mfek_pkg::MAX_NODES-1:0] adj_vld_q, adj_vld_d;
  logic [mfek_pkg::MAX_NODES-1:0] vis_q, vis_d;
  logic [QW-1:0]                 qhead_q, qhead_d, qtail_q, qtail_d;
  logic                          found_q, found_d;
  logic [CW-1:0]                 k_q, k_d;
  logic [NW-1:0]                 x_q, x_d, u_q, u_d;
  logic [mfek_pkg::BOT_W-1:0]    xb_q, xb_d, sb_q, sb_d;
  logic [mfek_pkg::TOTAL_W-1:0]  total_q, total_d;
  logic [1:0]                    rst_status_q, rst_status_d;
  logic                          out_vld_q;
  logic [1:0]                    out_status_q;
  logic [mfek_pkg::TOTAL_W-1:0]  out_flow_q;

  // ram ports
  logic                 arc_we, adj_we, node_we, q_we;
  logic [AW-1:0]        arc_waddr, arc_raddr;
  mfek_pkg::arc_t       arc_wdata, arc_rdata;
  logic [NW-1:0]        adj_waddr, adj_raddr, node_waddr, node_raddr, q_waddr, q_raddr;
  logic [AW-1:0]        adj_wdata, adj_rdata;
  mfek_pkg::node_t      node_wdata, node_rdata;
  logic [NW-1:0]        q_wdata, q_rdata;

  // arc evaluation
  logic signed [31:0]   resid;
  logic                 take;
  logic [mfek_pkg::BOT_W-1:0] nb;
  logic                 bad_edge, bad_solve, full;

  assign from_n = NW'(from8_q);
  assign to_n   = NW'(to8_q);
  assign src_n  = NW'(src8_q);
  assign snk_n  = NW'(snk8_q);

  assign bad_edge  = (32'(from8_q) >= 32'(mfek_pkg::MAX_NODES)) ||
                     (32'(to8_q) >= 32'(mfek_pkg::MAX_NODES));
  assign bad_solve = (32'(src8_q) >= 32'(mfek_pkg::MAX_NODES)) ||
                     (32'(snk8_q) >= 32'(mfek_pkg::MAX_NODES)) || (src8_q == snk8_q);
  assign full      = (32'(cnt_q) + 32'd2) > 32'(mfek_pkg::MAX_ARCS);

  // residual of the arc just read and the new bottleneck
  assign resid = $signed({2'b00, arc_rdata.cap}) - $signed({arc_rdata.flow[30], arc_rdata.flow});
  assign take  = !vis_q[arc_rdata.head] && (resid > 32'sd0);
  assign nb    = ($signed({1'b0, xb_q}) > resid) ? resid[mfek_pkg::BOT_W-1:0] : xb_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_flow_q};
  assign m_axis_tuser  = out_status_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    adj_vld_d    = adj_vld_q;
    vis_d        = vis_q;
    qhead_d      = qhead_q;
    qtail_d      = qtail_q;
    found_d      = found_q;
    k_d          = k_q;
    x_d          = x_q;
    u_d          = u_q;
    xb_d         = xb_q;
    sb_d         = sb_q;
    total_d      = total_q;
    rst_status_d = rst_status_q;

    arc_we     = 1'b0;
    arc_waddr  = cnt_q[AW-1:0];
    arc_wdata  = arc_rdata;
    arc_raddr  = k_q[AW-1:0];
    adj_we     = 1'b0;
    adj_waddr  = from_n;
    adj_wdata  = cnt_q[AW-1:0];
    adj_raddr  = from_n;
    node_we    = 1'b0;
    node_waddr = src_n;
    node_wdata = '{parent: '0, bot: mfek_pkg::START_BOT};
    node_raddr = x_q;
    q_we       = 1'b0;
    q_waddr    = qtail_q[NW-1:0];
    q_wdata    = src_n;
    q_raddr    = qhead_q[NW-1:0];

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == mfek_pkg::CMD_SOLVE) ? S_SLV_CHK : S_ADD_CHK;
        end
      end
      S_ADD_CHK: begin
        adj_raddr = from_n;
        if (bad_edge) begin
          rst_status_d = mfek_pkg::ST_BAD;
          state_d      = S_DONE;
        end else if (full) begin
          rst_status_d = mfek_pkg::ST_FULL;
          state_d      = S_DONE;
        end else begin
          rst_status_d = mfek_pkg::ST_OK;
          state_d      = S_ADD_W0;
        end
      end
      S_ADD_W0: begin
        arc_we         = 1'b1;
        arc_waddr      = cnt_q[AW-1:0];
        arc_wdata.tail = from_n;
        arc_wdata.head = to_n;
        arc_wdata.cap  = cap_q;
        arc_wdata.flow = '0;
        arc_wdata.next = adj_vld_q[from_n] ? CW'(adj_rdata) : mfek_pkg::ARC_EMPTY;
        adj_we         = 1'b1;
        adj_waddr      = from_n;
        adj_wdata      = cnt_q[AW-1:0];
        adj_vld_d[from_n] = 1'b1;
        adj_raddr      = to_n;
        state_d        = S_ADD_W1;
      end
      S_ADD_W1: begin
        arc_we         = 1'b1;
        arc_waddr      = cnt_q[AW-1:0] + AW'(1);
        arc_wdata.tail = to_n;
        arc_wdata.head = from_n;
        arc_wdata.cap  = '0;
        arc_wdata.flow = '0;
        if (to_n == from_n) begin
          arc_wdata.next = cnt_q;
        end else begin
          arc_wdata.next = adj_vld_q[to_n] ? CW'(adj_rdata) : mfek_pkg::ARC_EMPTY;
        end
        adj_we          = 1'b1;
        adj_waddr       = to_n;
        adj_wdata       = cnt_q[AW-1:0] + AW'(1);
        adj_vld_d[to_n] = 1'b1;
        cnt_d           = cnt_q + CW'(2);
        state_d         = S_DONE;
      end
      S_SLV_CHK: begin
        total_d = '0;
        if (bad_solve) begin
          rst_status_d = mfek_pkg::ST_BAD;
          state_d      = S_DONE;
        end else begin
          rst_status_d = mfek_pkg::ST_OK;
          state_d      = S_INIT;
        end
      end
      S_INIT: begin
        vis_d        = '0;
        vis_d[src_n] = 1'b1;
        node_we      = 1'b1;
        node_waddr   = src_n;
        node_wdata   = '{parent: '0, bot: mfek_pkg::START_BOT};
        q_we         = 1'b1;
        q_waddr      = '0;
        q_wdata      = src_n;
        qhead_d      = '0;
        qtail_d      = QW'(1);
        found_d      = 1'b0;
        state_d      = S_DEQ;
      end
      S_DEQ: begin
        if (qhead_q == qtail_q) begin
          state_d = S_DONE;
        end else begin
          q_raddr = qhead_q[NW-1:0];
          qhead_d = qhead_q + QW'(1);
          state_d = S_DEQ_RD;
        end
      end
      S_DEQ_RD: begin
        x_d        = q_rdata;
        adj_raddr  = q_rdata;
        node_raddr = q_rdata;
        state_d    = S_DEQ_LD;
      end
      S_DEQ_LD: begin
        k_d     = adj_vld_q[x_q] ? CW'(adj_rdata) : mfek_pkg::ARC_EMPTY;
        xb_d    = node_rdata.bot;
        state_d = S_ARC_RD;
      end
      S_ARC_RD: begin
        arc_raddr = k_q[AW-1:0];
        if (k_q >= cnt_q) begin
          if (found_q) begin
            u_d     = snk_n;
            state_d = S_AUG_RD;
          end else begin
            state_d = S_DEQ;
          end
        end else begin
          state_d = S_ARC_EV;
        end
      end
      S_ARC_EV: begin
        if (take) begin
          vis_d[arc_rdata.head] = 1'b1;
          node_we    = 1'b1;
          node_waddr = arc_rdata.head;
          node_wdata = '{parent: k_q[AW-1:0], bot: nb};
          if (32'(qtail_q) < 32'(mfek_pkg::MAX_NODES)) begin
            q_we    = 1'b1;
            q_waddr = qtail_q[NW-1:0];
            q_wdata = arc_rdata.head;
            qtail_d = qtail_q + QW'(1);
          end
          if (arc_rdata.head == snk_n) begin
            found_d = 1'b1;
            sb_d    = nb;
          end
        end
        k_d     = arc_rdata.next;
        state_d = S_ARC_RD;
      end
      S_AUG_RD: begin
        node_raddr = u_q;
        if (u_q == src_n) begin
          total_d = total_q + mfek_pkg::TOTAL_W'(sb_q);
          state_d = S_INIT;
        end else begin
          state_d = S_AUG_P;
        end
      end
      S_AUG_P: begin
        k_d       = CW'(node_rdata.parent);
        arc_raddr = node_rdata.parent;
        state_d   = S_AUG_F;
      end
      S_AUG_F: begin
        arc_we         = 1'b1;
        arc_waddr      = k_q[AW-1:0];
        arc_wdata      = arc_rdata;
        arc_wdata.flow = arc_rdata.flow + sb_q;
        u_d            = arc_rdata.tail;
        arc_raddr      = k_q[AW-1:0] ^ AW'(1);
        state_d        = S_AUG_R;
      end
      S_AUG_R: begin
        arc_we         = 1'b1;
        arc_waddr      = k_q[AW-1:0] ^ AW'(1);
        arc_wdata      = arc_rdata;
        arc_wdata.flow = arc_rdata.flow - sb_q;
        state_d        = S_AUG_RD;
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          if (cmd_q == mfek_pkg::CMD_SOLVE) begin
            adj_vld_d = '0;
            cnt_d     = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      adj_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      adj_vld_q <= adj_vld_d;
      if (state_q == S_DONE && (!out_vld_q || m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    vis_q        <= vis_d;
    qhead_q      <= qhead_d;
    qtail_q      <= qtail_d;
    found_q      <= found_d;
    k_q          <= k_d;
    x_q          <= x_d;
    u_q          <= u_d;
    xb_q         <= xb_d;
    sb_q         <= sb_d;
    total_q      <= total_d;
    rst_status_q <= rst_status_d;
    if (state_q == S_IDLE && s_axis_tvalid) begin
      cmd_q   <= s_axis_tuser;
      from8_q <= s_axis_tdata[7:0];
      to8_q   <= s_axis_tdata[15:8];
      cap_q   <= s_axis_tdata[45:16];
      src8_q  <= s_axis_tdata[53:46];
      snk8_q  <= s_axis_tdata[61:54];
    end
    if (state_q == S_DONE && (!out_vld_q || m_axis_tready)) begin
      out_status_q <= rst_status_q;
      out_flow_q   <= (cmd_q == mfek_pkg::CMD_SOLVE) ? total_q : '0;
    end
  end

  // arc store
  mfek_ram #(.WIDTH($bits(mfek_pkg::arc_t)), .DEPTH(mfek_pkg::MAX_ARCS)) u_arc_ram (
    .clk_i   (clk_i),
    .we_i    (arc_we),
    .waddr_i (arc_waddr),
    .wdata_i (arc_wdata),
    .raddr_i (arc_raddr),
    .rdata_o (arc_rdata)
  );

  // adjacency list heads
  mfek_ram #(.WIDTH(AW), .DEPTH(mfek_pkg::MAX_NODES)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  // per node bottleneck and parent arc
  mfek_ram #(.WIDTH($bits(mfek_pkg::node_t)), .DEPTH(mfek_pkg::MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  // bfs queue
  mfek_ram #(.WIDTH(NW), .DEPTH(mfek_pkg::MAX_NODES)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

`ifndef SYNTHESIS
  // arcs are always stored in pairs
  a_cnt_even: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q[0] == 1'b0)
    else $error("arc count odd");

  // arc count never passes the store size
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(mfek_pkg::MAX_ARCS))
    else $error("arc count overflow");

  // queue read pointer never passes the write pointer during a search
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEQ || state_q == S_ARC_RD) |-> qhead_q <= qtail_q)
    else $error("queue underrun");

  // a solve always ends with an empty graph
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && state_d == S_IDLE && cmd_q == mfek_pkg::CMD_SOLVE)
    |=> (cnt_q == '0 && adj_vld_q == '0))
    else $error("graph not cleared");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the edmonds-karp max flow engine
// Loads random and directed graphs edge by edge, solves them, and checks each
// status and flow total against an in-bench max flow calculation.
// ----------------------------------------------------------------------------

module tb_top;

  typedef struct packed {
    logic                        cmd;
    logic [mfek_pkg::NODE_W-1:0] from_n;
    logic [mfek_pkg::NODE_W-1:0] to_n;
    logic [mfek_pkg::CAP_W-1:0]  cap;
    logic [mfek_pkg::NODE_W-1:0] src;
    logic [mfek_pkg::NODE_W-1:0] snk;
    logic                        drain;
  } request_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [mfek_pkg::TOTAL_W-1:0] flow;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  max_flow_edmonds_karp_top dut (.*);

  request_t pending_q[$];
  answer_t  answer_q[$];
  request_t cur_req;
  int       errors = 0;
  int       n_adds = 0, n_solves = 0, n_full = 0, n_bad = 0, n_results = 0;
  int       idle_cycles = 0;
  bit       stim_done = 0;
  bit       in_acc = 0;
  int       in_gap = 0, out_gap = 0;
  bit       in_burst = 0, out_burst = 0;

  // graph mirror
  int     g_tail [mfek_pkg::MAX_ARCS];
  int     g_head [mfek_pkg::MAX_ARCS];
  longint g_cap  [mfek_pkg::MAX_ARCS];
  longint g_flow [mfek_pkg::MAX_ARCS];
  int     g_next [mfek_pkg::MAX_ARCS];
  int     g_adj  [mfek_pkg::MAX_NODES];
  int     g_count;
  longint n_bot  [mfek_pkg::MAX_NODES];
  int     n_par  [mfek_pkg::MAX_NODES];
  int     bfs_q  [mfek_pkg::MAX_NODES];

  function automatic void graph_clear();
    for (int i = 0; i < mfek_pkg::MAX_NODES; i++) g_adj[i] = mfek_pkg::MAX_ARCS;
    g_count = 0;
  endfunction

  function automatic void arc_link(int f, int t, longint c);
    g_tail[g_count] = f;
    g_head[g_count] = t;
    g_cap[g_count]  = c;
    g_flow[g_count] = 0;
    g_next[g_count] = g_adj[f];
    g_adj[f] = g_count;
    g_count++;
  endfunction

  // repeated bfs augmentation, returns total flow
  function automatic longint flow_solve(int s, int t);
    longint total;
    longint b;
    longint r;
    int qh, qt, x, y, k, u;
    total = 0;
    forever begin
      for (int i = 0; i < mfek_pkg::MAX_NODES; i++) n_bot[i] = 0;
      n_bot[s] = longint'(mfek_pkg::START_BOT);
      qh = 0;
      qt = 0;
      bfs_q[qt++] = s;
      while (qh < qt) begin
        x = bfs_q[qh++];
        k = g_adj[x];
        while (k < g_count) begin
          y = g_head[k];
          r = g_cap[k] - g_flow[k];
          if (n_bot[y] == 0 && r > 0) begin
            b = n_bot[x];
            if (b > r) b = r;
            n_par[y] = k;
            n_bot[y] = b;
            if (qt < mfek_pkg::MAX_NODES) bfs_q[qt++] = y;
          end
          k = g_next[k];
        end
        if (n_bot[t] != 0) break;
      end
      b = n_bot[t];
      if (b == 0) break;
      u = t;
      while (u != s) begin
        k = n_par[u];
        g_flow[k] += b;
        g_flow[k ^ 1] -= b;
        u = g_tail[k];
      end
      total += b;
    end
    return total;
  endfunction

  function automatic answer_t predict(request_t rq);
    answer_t a;
    a.status = mfek_pkg::ST_OK;
    a.flow   = '0;
    if (rq.cmd == mfek_pkg::CMD_ADD) begin
      if (g_count + 2 > mfek_pkg::MAX_ARCS) begin
        a.status = mfek_pkg::ST_FULL;
        n_full++;
      end else begin
        arc_link(int'(rq.from_n), int'(rq.to_n), longint'(rq.cap));
        arc_link(int'(rq.to_n), int'(rq.from_n), 0);
      end
    end else begin
      if (rq.src == rq.snk) begin
        a.status = mfek_pkg::ST_BAD;
        n_bad++;
      end else begin
        a.flow = mfek_pkg::TOTAL_W'(flow_solve(int'(rq.src), int'(rq.snk)));
      end
      graph_clear();
    end
    return a;
  endfunction

  task automatic push_add(int f, int t, logic [mfek_pkg::CAP_W-1:0] c);
    request_t rq;
    rq = '0;
    rq.cmd = mfek_pkg::CMD_ADD;
    rq.from_n = mfek_pkg::NODE_W'(f);
    rq.to_n = mfek_pkg::NODE_W'(t);
    rq.cap = c;
    rq.src = mfek_pkg::NODE_W'($urandom);
    rq.snk = mfek_pkg::NODE_W'($urandom);
    pending_q.insert(pending_q.size(), rq);
  endtask

  task automatic push_solve(int s, int t, bit drain);
    request_t rq;
    rq = '0;
    rq.cmd = mfek_pkg::CMD_SOLVE;
    rq.from_n = mfek_pkg::NODE_W'($urandom);
    rq.to_n = mfek_pkg::NODE_W'($urandom);
    rq.cap = mfek_pkg::CAP_W'($urandom);
    rq.src = mfek_pkg::NODE_W'(s);
    rq.snk = mfek_pkg::NODE_W'(t);
    rq.drain = drain;
    pending_q.insert(pending_q.size(), rq);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // stimulus
  initial begin
    int base, span, ne, f, t, c;
    graph_clear();
    // directed: extremes of capacity, single edge, zero edge, self loop, parallel edges
    push_add(0, 255, 30'h3fff_ffff);
    push_solve(0, 255, 0);
    push_add(255, 0, 30'h0);
    push_add(255, 255, 30'h3fff_ffff);
    push_solve(255, 0, 0);
    push_add(1, 2, 30'h3fff_ffff);
    push_add(1, 2, 30'h3fff_ffff);
    push_add(2, 3, 30'h2aaa_aaaa);
    push_add(2, 3, 30'h1555_5555);
    push_solve(1, 3, 1);
    // source equal to sink still clears the graph
    push_add(4, 5, 30'd7);
    push_solve(4, 4, 0);
    push_solve(4, 5, 0);
    // no path
    push_add(9, 8, 30'd3);
    push_solve(8, 9, 0);
    // fill the arc store, then overflow
    for (int i = 0; i < mfek_pkg::MAX_ARCS / 2 + 3; i++)
      push_add($urandom_range(0, 7), $urandom_range(0, 7),
               mfek_pkg::CAP_W'($urandom_range(1, 1000)));
    push_solve(0, 7, 1);
    // random graphs, mostly small
    while (pending_q.size() < 1100) begin
      base = $urandom_range(0, 240);
      span = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(2, 12);
      if (base + span > 256) base = 256 - span;
      ne = $urandom_range(0, 14);
      for (int i = 0; i < ne; i++) begin
        f = base + $urandom_range(0, span - 1);
        t = base + $urandom_range(0, span - 1);
        case ($urandom_range(0, 3))
          0: c = {$urandom} & 32'h3fff_ffff;
          1: c = $urandom_range(0, 1) ? 32'h3fff_ffff : 0;
          default: c = $urandom_range(0, 20);
        endcase
        push_add(f, t, mfek_pkg::CAP_W'(c));
      end
      if ($urandom_range(0, 9) == 0) begin
        f = $urandom_range(0, 255);
        push_solve(f, f, $urandom_range(0, 7) == 0);
      end else begin
        push_solve(base + $urandom_range(0, span - 1), base + $urandom_range(0, span - 1),
                   $urandom_range(0, 7) == 0);
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_acc) begin
        if ($urandom_range(0, 199) == 0) in_burst = ~in_burst;
        if (in_gap > 0 && !in_burst) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && answer_q.size() > 0)) begin
          cur_req = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_req.cmd;
          s_axis_tdata  <= {2'b00, cur_req.snk, cur_req.src, cur_req.cap,
                            cur_req.to_n, cur_req.from_n};
          in_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
          if (pending_q.size() == 0) stim_done = 1;
        end
      end
      if ($urandom_range(0, 199) == 0) out_burst = ~out_burst;
      if (out_gap > 0 && !out_burst) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  // predict on request, check on result
  always @(posedge clk_i) begin
    answer_t exp_a;
    in_acc = s_axis_tvalid && s_axis_tready;
    idle_cycles++;
    if (in_acc) begin
      idle_cycles = 0;
      if (cur_req.cmd == mfek_pkg::CMD_ADD) n_adds++;
      else n_solves++;
      answer_q.insert(answer_q.size(), predict(cur_req));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      idle_cycles = 0;
      n_results++;
      if (answer_q.size() == 0) begin
        $error("result with no request pending: status %0d flow %0d",
               m_axis_tuser, m_axis_tdata[38:0]);
        errors++;
      end else begin
        exp_a = answer_q.pop_front();
        if (m_axis_tuser !== exp_a.status) begin
          $error("status: expected %0d, got %0d", exp_a.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[38:0] !== exp_a.flow) begin
          $error("max_flow: expected %0d, got %0d", exp_a.flow, m_axis_tdata[38:0]);
          errors++;
        end
      end
    end
  end

  // end of run and watchdog
  initial begin
    wait (stim_done && answer_q.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("covered %0d edge adds (%0d dropped, store full) and %0d solves (%0d bad nodes)",
             n_adds, n_full, n_solves, n_bad);
    $display("%0d results checked", n_results);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("PASS max_flow_edmonds_karp_top");
    end else begin
      $display("FAIL max_flow_edmonds_karp_top");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= 20000000);
    $display("timeout: no request or result moved");
    $display("FAIL max_flow_edmonds_karp_top");
    $finish;
  end

endmodule

[files.f]
src/mfek_pkg.sv
src/mfek_ram.sv
src/max_flow_edmonds_karp_top.sv
verif/tb_top.sv
